// File: hw/rtl/iirl_pkg.sv
// Package: sizes, codes and shared types of the indexed insert/remove list.
package iirl_pkg;

	localparam int CAPACITY   = 64;
	localparam int ITEM_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int GROUP      = 8;
	localparam int NUM_GROUPS = (CAPACITY + GROUP - 1) / GROUP;

	localparam int CMD_W    = 3;
	localparam int POS_W    = 7;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [ITEM_WIDTH-1:0] item_t;
	typedef logic [NUM_GROUPS-1:0][ITEM_WIDTH-1:0] group_vec_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_REMOVE = 3'd2,
		CMD_READ   = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_e;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FULL      = 2'd2
	} status_e;

	typedef enum logic [1:0] {
		MODE_HOLD   = 2'd0,
		MODE_WRITE  = 2'd1,
		MODE_INSERT = 2'd2,
		MODE_REMOVE = 2'd3
	} mode_e;

	typedef struct packed {
		mode_e mode;
		idx_t  at;
		item_t data;
		idx_t  rd_at;
	} bcast_t;

endpackage

// File: hw/rtl/iirl_if.sv
// Interfaces: command channel and result channel with valid/ready handshake.
interface iirl_req_if;
	import iirl_pkg::*;
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [POS_W-1:0]   position;
	logic [VALUE_W-1:0] value_in;

	modport source (output valid, output command, output position, output value_in,
		input ready);
	modport sink (input valid, input command, input position, input value_in,
		output ready);
endinterface

interface iirl_rsp_if;
	import iirl_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [VALUE_W-1:0]  read_value;
	logic [COUNT_W-1:0]  count;
	logic                is_empty;

	modport source (output valid, output status, output read_value, output count,
		output is_empty, input ready);
	modport sink (input valid, input status, input read_value, input count,
		input is_empty, output ready);
endinterface

// File: hw/rtl/iirl_cell.sv
// Cell: one list entry that loads new data, its left or its right neighbor.
module iirl_cell (
	input  logic            clk,
	input  iirl_pkg::idx_t  index,
	input  iirl_pkg::bcast_t bcast,
	input  iirl_pkg::item_t left,
	input  iirl_pkg::item_t right,
	output iirl_pkg::item_t q,
	output iirl_pkg::item_t rd
);
	import iirl_pkg::*;

	item_t entry_q;
	logic  eq_at;
	logic  gt_at;

	assign eq_at = (index == bcast.at);
	assign gt_at = (index > bcast.at);

	always_ff @(posedge clk) begin
		case (bcast.mode)
			MODE_WRITE: begin
				if (eq_at) entry_q <= bcast.data;
			end
			MODE_INSERT: begin
				if (eq_at) entry_q <= bcast.data;
				else if (gt_at) entry_q <= left;
			end
			MODE_REMOVE: begin
				if (eq_at || gt_at) entry_q <= right;
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

	assign q  = entry_q;
	assign rd = (index == bcast.rd_at) ? entry_q : '0;
endmodule

// File: hw/rtl/iirl_chain.sv
// Chain: row of list cells with registered group read-out.
module iirl_chain (
	input  logic                 clk,
	input  iirl_pkg::bcast_t     bcast,
	output iirl_pkg::group_vec_t grp_s1
);
	import iirl_pkg::*;

	item_t      q   [CAPACITY];
	item_t      rd  [CAPACITY];
	group_vec_t grp;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		item_t left_d;
		item_t right_d;
		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = q[i+1];
		end
		iirl_cell u_cell (
			.clk   (clk),
			.index (IDX_W'(i)),
			.bcast (bcast),
			.left  (left_d),
			.right (right_d),
			.q     (q[i]),
			.rd    (rd[i])
		);
	end

	always_comb begin
		grp = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			for (int k = 0; k < GROUP; k++) begin
				if (g * GROUP + k < CAPACITY) grp[g] = grp[g] | rd[g * GROUP + k];
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_s1 <= grp;
	end
endmodule

// File: hw/rtl/indexed_insert_remove_list_core.sv
// Top level: indexed insert/remove list built as a shifting row of cells.
//
// Channels: req (sink) carries command, position and value_in; rsp (source)
// carries status, read_value, count and is_empty. A word moves on either
// channel at a rising clock edge with valid and ready both high.
// Every command word yields exactly one result word, in order.
// The result is registered in v_s1, then in the output register. req.ready
// is low while a command sits in v_s1, so a new command is taken only once
// the last has left that stage; the cell row read-out is registered in two
// levels (grp_s1, then out_rd_q). All cells move to a neighbor together, so
// insert and remove take the same time at any position.
// Reset (arst_n low): the list length becomes zero and no result is pending;
// the cell contents are not cleared and are never read before being written.
// When the receiver stalls, the result is held in the output register and
// req.ready stays low until that word is taken.
module indexed_insert_remove_list_core (
	input  logic  clk,
	input  logic  arst_n,
	iirl_req_if.sink   req,
	iirl_rsp_if.source rsp
);
	import iirl_pkg::*;

	cnt_t       count_q;
	logic       v_s1;
	logic       read_en_s1;
	status_e    status_s1;
	cnt_t       count_s1;
	logic       out_v_q;
	status_e    out_status_q;
	item_t      out_rd_q;
	cnt_t       out_count_q;
	group_vec_t grp_s1;
	bcast_t     bcast;
	logic       accept;
	logic       full;
	mode_e      mode;
	idx_t       at;
	status_e    status;
	cnt_t       count_d;
	logic       read_en;
	item_t      rd_or;

	assign req.ready = !v_s1 && (!out_v_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign full      = (32'(count_q) >= 32'(CAPACITY));

	always_comb begin
		mode    = MODE_HOLD;
		at      = IDX_W'(req.position);
		status  = ST_OK;
		count_d = count_q;
		read_en = 1'b0;
		case (cmd_e'(req.command))
			CMD_APPEND: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					mode    = MODE_WRITE;
					at      = IDX_W'(count_q);
					count_d = count_q + 1'b1;
				end
			end
			CMD_INSERT: begin
				if (32'(req.position) > 32'(count_q)) begin
					status = ST_BAD_INDEX;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					mode    = MODE_INSERT;
					count_d = count_q + 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (32'(req.position) >= 32'(count_q)) begin
					status = ST_BAD_INDEX;
				end else begin
					mode    = MODE_REMOVE;
					count_d = count_q - 1'b1;
				end
			end
			CMD_READ: begin
				if (32'(req.position) >= 32'(count_q)) status = ST_BAD_INDEX;
				else read_en = 1'b1;
			end
			CMD_CLEAR: begin
				count_d = '0;
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	assign bcast.mode  = accept ? mode : MODE_HOLD;
	assign bcast.at    = at;
	assign bcast.data  = item_t'(req.value_in);
	assign bcast.rd_at = IDX_W'(req.position);

	iirl_chain u_chain (
		.clk    (clk),
		.bcast  (bcast),
		.grp_s1 (grp_s1)
	);

	always_comb begin
		rd_or = '0;
		for (int g = 0; g < NUM_GROUPS; g++) rd_or = rd_or | grp_s1[g];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (accept) count_q <= count_d;
			v_s1 <= accept;
			if (v_s1) out_v_q <= 1'b1;
			else if (rsp.ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1  <= status;
			count_s1   <= count_d;
			read_en_s1 <= read_en;
		end
		if (v_s1) begin
			out_status_q <= status_s1;
			out_count_q  <= count_s1;
			out_rd_q     <= read_en_s1 ? rd_or : '0;
		end
	end

	assign rsp.valid      = out_v_q;
	assign rsp.status     = out_status_q;
	assign rsp.read_value = VALUE_W'(out_rd_q);
	assign rsp.count      = COUNT_W'(out_count_q);
	assign rsp.is_empty   = (out_count_q == '0);
endmodule
